[rtl/core/grid_raycast_column_renderer_macros.svh]
// Assertion helpers for the ray-cast column renderer.
`ifndef GRID_RAYCAST_COLUMN_RENDERER_MACROS_SVH
`define GRID_RAYCAST_COLUMN_RENDERER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define GRC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define GRC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/grc_pkg.sv]
// ---------------------------------------------------------------------------
// grc_pkg
// Shared types and constants of the ray-cast column renderer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package grc_pkg;

    localparam int MAP_DIM   = 16;
    localparam int NUM_REGS  = 8;
    localparam int FOV_UNITS = 8188;
    localparam int FOV_HALF  = 4094;
    localparam int ONE_Q14   = 16384;
    localparam int MAX_STEPS = 256;

    localparam logic [15:0] GLYPH_SPACE = 16'h0020;
    localparam logic [15:0] GLYPH_FULL  = 16'h2588;
    localparam logic [15:0] GLYPH_DARK  = 16'h2593;
    localparam logic [15:0] GLYPH_MED   = 16'h2592;
    localparam logic [15:0] GLYPH_LIGHT = 16'h2591;
    localparam logic [15:0] GLYPH_HASH  = 16'h0023;
    localparam logic [15:0] GLYPH_X     = 16'h0078;
    localparam logic [15:0] GLYPH_DOT   = 16'h002E;
    localparam logic [15:0] GLYPH_DASH  = 16'h002D;

    // Ray job handed from the front to the back.
    typedef struct packed {
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic signed [15:0] sin_x;
        logic signed [15:0] cos_y;
    } ray_job_t;

    // Quarter-wave sine table, Q1.14.
    function automatic logic [14:0] quarter_wave(input logic [4:0] idx);
        logic [14:0] v;
        begin
            v = 15'd0;
            case (idx)
                5'd0:  v = 15'd0;
                5'd1:  v = 15'd1606;
                5'd2:  v = 15'd3196;
                5'd3:  v = 15'd4756;
                5'd4:  v = 15'd6270;
                5'd5:  v = 15'd7723;
                5'd6:  v = 15'd9102;
                5'd7:  v = 15'd10394;
                5'd8:  v = 15'd11585;
                5'd9:  v = 15'd12665;
                5'd10: v = 15'd13623;
                5'd11: v = 15'd14449;
                5'd12: v = 15'd15137;
                5'd13: v = 15'd15679;
                5'd14: v = 15'd16069;
                5'd15: v = 15'd16305;
                default: v = 15'd16384;
            endcase
            return v;
        end
    endfunction

    // Quarter-wave sine with linear interpolation; p in 0..16384.
    function automatic logic [14:0] quarter_sin(input logic [14:0] p);
        logic [4:0]  i;
        logic [9:0]  f;
        logic [14:0] a;
        logic [14:0] b;
        logic [24:0] prod;
        begin
            i    = p[14:10];
            f    = p[9:0];
            a    = quarter_wave(i);
            b    = quarter_wave(i + 5'd1);
            prod = 25'(b - a) * 25'(f);
            if (p >= 15'(ONE_Q14)) return 15'(ONE_Q14);
            return a + prod[24:10];
        end
    endfunction

    // Full-circle sine in Q1.14.
    function automatic logic signed [15:0] sin_q14(input logic [15:0] ang);
        logic [14:0] r;
        logic [14:0] q;
        begin
            r = {1'b0, ang[13:0]};
            if (ang[14]) q = quarter_sin(15'(ONE_Q14) - r);
            else q = quarter_sin(r);
            if (ang[15]) return -$signed({1'b0, q});
            return $signed({1'b0, q});
        end
    endfunction

endpackage
`default_nettype wire

[rtl/core/grid_raycast_column_renderer.sv]
// Ray-cast column renderer. Each input transfer is one screen column with the
// player pose; it yields SCREEN_HEIGHT output transfers, one glyph per row, top
// to bottom, with tlast on the bottom row. The front registers the pose and
// looks up the column offset, then forms the direction vector. The back takes
// the job, steps the ray a tenth of a cell at a time (up to MAX_STEPS = 256
// steps), runs the ceiling division one quotient bit at a time and emits the
// rows, stalling while the receiver is not ready. The back takes a new column
// only when idle; a two-entry queue lets the front prepare the next columns
// while the back works.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_raycast_column_renderer_macros.svh"
// ---------------------------------------------------------------------------
// grid_raycast_column_renderer
// Top level: wall map registers, front, queue and back.
// ---------------------------------------------------------------------------
module grid_raycast_column_renderer #(
    parameter int SCREEN_WIDTH  = 120,
    parameter int SCREEN_HEIGHT = 40,
    parameter int MAX_DEPTH     = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // pos_x_fix, pos_y_fix, heading, column, pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // row, glyph, pad
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    logic [31:0]       map_reg [grc_pkg::NUM_REGS];
    logic [255:0]      map_bits;
    logic              fj_valid, fj_ready, bj_valid, bj_ready;
    grc_pkg::ray_job_t fjob, bjob;
    logic [5:0]        row;
    logic [15:0]       glyph;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {2'b00, glyph, row};

    // Hold the wall map
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg[0] <= 32'd2147614719;
            map_reg[1] <= 32'd2214559745;
            map_reg[2] <= 32'd2147581953;
            map_reg[3] <= 32'd2147581953;
            map_reg[4] <= 32'd2147581953;
            map_reg[5] <= 32'd2147581953;
            map_reg[6] <= 32'd2147594265;
            map_reg[7] <= 32'd4294934529;
        end else if (cfg_valid) begin
            map_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb begin
        for (int k = 0; k < grc_pkg::NUM_REGS; k++) map_bits[k*32 +: 32] = map_reg[k];
    end

    grc_front #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .pos_x_fix(s_tdata[15:0]), .pos_y_fix(s_tdata[31:16]),
        .heading(s_tdata[47:32]), .column(s_tdata[54:48]),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fjob)
    );

    grc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fjob),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bjob)
    );

    grc_back #(.SCREEN_HEIGHT(SCREEN_HEIGHT), .MAX_DEPTH(MAX_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .map_bits(map_bits),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bjob),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_row(row), .m_glyph(glyph), .m_last(m_tlast)
    );

    `GRC_ASSERT_IMPL(a_last_row, aclk, aresetn, m_tvalid && m_tlast, row == 6'(SCREEN_HEIGHT - 1), "tlast off bottom row")
    `GRC_ASSERT_IMPL(a_row_range, aclk, aresetn, m_tvalid, 7'(row) < 7'(SCREEN_HEIGHT), "row out of range")
    `GRC_ASSERT_NEXT(a_row_seq, aclk, aresetn, m_tvalid && m_tready && !m_tlast, !m_tvalid || row == $past(row) + 6'd1, "row sequence broken")

endmodule
`default_nettype wire

[rtl/core/grc_front.sv]
// ---------------------------------------------------------------------------
// grc_front
// Accepts a pose and column, forms the ray angle and its direction vector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module grc_front #(
    parameter int SCREEN_WIDTH = 120
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [15:0]       pos_x_fix,
    input  wire logic [15:0]       pos_y_fix,
    input  wire logic [15:0]       heading,
    input  wire logic [6:0]        column,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output grc_pkg::ray_job_t      job
);
    localparam logic [15:0] FOV_HALF16 = 16'(grc_pkg::FOV_HALF);

    // Stage 0: registered inputs and column offset; stage 1: direction vector
    logic              busy_reg;
    logic [15:0]       px_reg, py_reg, head_reg;
    logic [15:0]       quo_reg;
    logic              out_valid_reg;
    grc_pkg::ray_job_t job_reg;
    logic [15:0]       ang;
    logic              emit;
    wire  [15:0]       off_tab [128];

    // Column offset table: column * FOV / width, truncated
    for (genvar c = 0; c < 128; c++) begin : g_off
        assign off_tab[c] = 16'((c * grc_pkg::FOV_UNITS) / SCREEN_WIDTH);
    end

    assign in_ready  = !busy_reg;
    assign job_valid = out_valid_reg;
    assign job       = job_reg;
    assign ang       = head_reg - FOV_HALF16 + quo_reg;
    assign emit      = busy_reg && (!out_valid_reg || job_ready);

    // Register the pose, then hand the ray job to the queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && job_ready && !emit) out_valid_reg <= 1'b0;
            if (!busy_reg && in_valid) begin
                busy_reg <= 1'b1;
                px_reg   <= pos_x_fix;
                py_reg   <= pos_y_fix;
                head_reg <= heading;
                quo_reg  <= off_tab[column];
            end else if (emit) begin
                job_reg.pos_x <= px_reg;
                job_reg.pos_y <= py_reg;
                job_reg.sin_x <= grc_pkg::sin_q14(ang);
                job_reg.cos_y <= grc_pkg::sin_q14(ang + 16'h4000);
                out_valid_reg <= 1'b1;
                busy_reg      <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/grc_queue.sv]
// ---------------------------------------------------------------------------
// grc_queue
// Two-entry queue between the front and the ray marcher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module grc_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  grc_pkg::ray_job_t      wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output grc_pkg::ray_job_t      rd_data
);
    grc_pkg::ray_job_t mem_reg [2];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_reg;
    logic              do_wr, do_rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Store entry
    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wp_reg] <= wr_data;
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_wr) wp_reg <= !wp_reg;
            if (do_rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end
endmodule
`default_nettype wire

[rtl/core/grc_back.sv]
// ---------------------------------------------------------------------------
// grc_back
// Marches the ray, derives ceiling and shade, emits one glyph per row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module grc_back #(
    parameter int SCREEN_HEIGHT = 40,
    parameter int MAX_DEPTH     = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [255:0]      map_bits,
    input  wire logic              job_valid,
    output logic                   job_ready,
    input  grc_pkg::ray_job_t      job,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [5:0]             m_row,
    output logic [15:0]            m_glyph,
    output logic                   m_last
);
    localparam int D10MAX = 10 * MAX_DEPTH;
    localparam logic signed [24:0] CELL = 25'sd163840;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MARCH = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_SHADE = 5'b01000,
        ST_EMIT  = 5'b10000
    } st_t;

    st_t                st_reg;
    logic signed [24:0] rx_reg, ry_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic [8:0]         n_reg;
    logic [9:0]         d10_reg;
    logic [15:0]        num_reg;
    logic [15:0]        rem_reg;
    logic [15:0]        quo_reg;
    logic [4:0]         dcnt_reg;
    logic               neg_reg;
    logic signed [15:0] ceil_reg;
    logic [15:0]        shade_reg;
    logic [5:0]         y_reg;
    logic               ov_reg;
    logic [5:0]         orow_reg;
    logic [15:0]        oglyph_reg;
    logic               olast_reg;

    logic signed [24:0] nx, ny;
    logic               outx, outy, wall;
    logic [3:0]         cx, cy;
    logic [14:0]        qx_mul, qy_mul;
    logic [16:0]        trial;
    logic [10:0]        den;
    logic [15:0]        g;
    logic signed [15:0] floor_row;
    logic [6:0]         rem_rows;
    logic signed [15:0] ys;
    logic               emit_row;

    assign job_ready = st_reg == ST_IDLE;
    assign m_valid   = ov_reg;
    assign m_row     = orow_reg;
    assign m_glyph   = oglyph_reg;
    assign m_last    = olast_reg;

    // Next ray point; a point in (-1,0) cells still truncates to cell 0
    assign nx   = rx_reg + 25'(dx_reg);
    assign ny   = ry_reg + 25'(dy_reg);
    assign outx = (nx <= -CELL) || (nx >= 25'sd16 * CELL);
    assign outy = (ny <= -CELL) || (ny >= 25'sd16 * CELL);
    // Cell index: drop 15 bits, then divide by five through 205/1024
    assign qx_mul = 15'(nx[21:15]) * 15'd205;
    assign qy_mul = 15'(ny[21:15]) * 15'd205;
    assign cx   = nx[24] ? 4'd0 : qx_mul[13:10];
    assign cy   = ny[24] ? 4'd0 : qy_mul[13:10];
    assign wall = map_bits[{cy, cx}];

    assign den   = {d10_reg, 1'b0};
    assign trial = {rem_reg, num_reg[15]};

    assign emit_row = (st_reg == ST_EMIT) && (!ov_reg || m_ready);

    // Row glyph
    assign floor_row = 16'(SCREEN_HEIGHT) - ceil_reg;
    assign ys        = 16'(y_reg);
    assign rem_rows  = 7'(SCREEN_HEIGHT) - 7'(y_reg);
    always_comb begin
        if (ys <= ceil_reg) g = grc_pkg::GLYPH_SPACE;
        else if (ys <= floor_row) g = shade_reg;
        else if (8 * int'(rem_rows) < SCREEN_HEIGHT) g = grc_pkg::GLYPH_HASH;
        else if (4 * int'(rem_rows) < SCREEN_HEIGHT) g = grc_pkg::GLYPH_X;
        else if (8 * int'(rem_rows) < 3 * SCREEN_HEIGHT) g = grc_pkg::GLYPH_DOT;
        else if (20 * int'(rem_rows) < 9 * SCREEN_HEIGHT) g = grc_pkg::GLYPH_DASH;
        else g = grc_pkg::GLYPH_SPACE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end else begin
            if (ov_reg && m_ready && !emit_row) ov_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        rx_reg  <= 25'(job.pos_x) * 25'sd40;
                        ry_reg  <= 25'(job.pos_y) * 25'sd40;
                        dx_reg  <= job.sin_x;
                        dy_reg  <= job.cos_y;
                        n_reg   <= 9'd1;
                        d10_reg <= 10'(D10MAX);
                        st_reg  <= ST_MARCH;
                    end
                end
                // Step the ray one tenth of a cell
                ST_MARCH: begin
                    rx_reg <= nx;
                    ry_reg <= ny;
                    n_reg  <= n_reg + 9'd1;
                    if (outx || outy) begin
                        st_reg <= ST_DIV;
                    end else if (wall) begin
                        d10_reg <= 10'(n_reg);
                        st_reg  <= ST_DIV;
                    end else if (n_reg == 9'(grc_pkg::MAX_STEPS)) begin
                        st_reg <= ST_DIV;
                    end
                end
                // Set up the ceiling division and pick the wall shade
                ST_DIV: begin
                    if (int'(d10_reg) >= 20) num_reg <= 16'(SCREEN_HEIGHT * (int'(d10_reg) - 20));
                    else num_reg <= 16'(SCREEN_HEIGHT * (20 - int'(d10_reg)));
                    neg_reg  <= int'(d10_reg) < 20;
                    rem_reg  <= 16'd0;
                    quo_reg  <= 16'd0;
                    dcnt_reg <= 5'd16;
                    st_reg   <= ST_SHADE;
                    if (4 * int'(d10_reg) <= D10MAX) shade_reg <= grc_pkg::GLYPH_FULL;
                    else if (3 * int'(d10_reg) < D10MAX) shade_reg <= grc_pkg::GLYPH_DARK;
                    else if (2 * int'(d10_reg) < D10MAX) shade_reg <= grc_pkg::GLYPH_MED;
                    else if (int'(d10_reg) < D10MAX) shade_reg <= grc_pkg::GLYPH_LIGHT;
                    else shade_reg <= grc_pkg::GLYPH_SPACE;
                end
                // One quotient bit a cycle, truncation toward zero
                ST_SHADE: begin
                    if (dcnt_reg == 5'd0) begin
                        ceil_reg <= neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
                        y_reg    <= 6'd0;
                        st_reg   <= ST_EMIT;
                    end else begin
                        num_reg <= {num_reg[14:0], 1'b0};
                        if (trial >= 17'(den)) begin
                            rem_reg <= 16'(trial - 17'(den));
                            quo_reg <= {quo_reg[14:0], 1'b1};
                        end else begin
                            rem_reg <= trial[15:0];
                            quo_reg <= {quo_reg[14:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg - 5'd1;
                    end
                end
                // Emit rows top to bottom
                ST_EMIT: begin
                    if (emit_row) begin
                        ov_reg     <= 1'b1;
                        orow_reg   <= y_reg;
                        oglyph_reg <= g;
                        olast_reg  <= y_reg == 6'(SCREEN_HEIGHT - 1);
                        y_reg      <= y_reg + 6'd1;
                        if (y_reg == 6'(SCREEN_HEIGHT - 1)) st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[tb/sv/grid_raycast_column_renderer_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ray-cast column renderer testbench
// Drives directed and random columns across several wall maps, idle and
// stall patterns, predicts the 40 row glyphs of each column and checks every
// output transfer in order.
// ---------------------------------------------------------------------------

class column_scoreboard;
    logic [31:0] map_word [8];
    logic [5:0]  row_q    [$];
    logic [15:0] glyph_q  [$];
    logic        last_q   [$];
    int          errors;

    function new();
        errors = 0;
        map_word[0] = 32'd2147614719; map_word[1] = 32'd2214559745;
        map_word[2] = 32'd2147581953; map_word[3] = 32'd2147581953;
        map_word[4] = 32'd2147581953; map_word[5] = 32'd2147581953;
        map_word[6] = 32'd2147594265; map_word[7] = 32'd4294934529;
    endfunction

    function int wave(int i);
        int t [17];
        t = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
              12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};
        return t[i];
    endfunction

    function int qsin(int p);
        int i;
        int f;
        if (p >= 16384) return 16384;
        i = p >> 10;
        f = p & 1023;
        return wave(i) + (((wave(i + 1) - wave(i)) * f) >> 10);
    endfunction

    function int sine(int a);
        int r;
        a = a & 16'hFFFF;
        r = a & 16'h3FFF;
        case (a >> 14)
            0: return qsin(r);
            1: return qsin(16384 - r);
            2: return -qsin(r);
            default: return -qsin(16384 - r);
        endcase
    endfunction

    // Cast the ray and queue the 40 glyphs of one column.
    function void note_column(logic [15:0] px, logic [15:0] py, logic [15:0] hd,
                              logic [6:0] col);
        longint sx, sy, cx, cy;
        int ang, d10, ceil_r, floor_r, rem;
        logic [15:0] shade, g;
        d10 = 160;
        ang = (int'(hd) + 65536 - 4094 + (int'(col) * 8188) / 120) & 16'hFFFF;
        sx = sine(ang);
        sy = sine(ang + 16384);
        for (int n = 1; n <= 256; n++) begin
            cx = (longint'(px) * 40 + sx * n) / 163840;
            cy = (longint'(py) * 40 + sy * n) / 163840;
            if (cx < 0 || cx >= 16 || cy < 0 || cy >= 16) break;
            if (map_word[cy >> 1][cx + ((cy & 1) << 4)]) begin
                d10 = n;
                break;
            end
        end
        ceil_r = (40 * d10 - 800) / (2 * d10);
        floor_r = 40 - ceil_r;
        if (4 * d10 <= 160) shade = grc_pkg::GLYPH_FULL;
        else if (3 * d10 < 160) shade = grc_pkg::GLYPH_DARK;
        else if (2 * d10 < 160) shade = grc_pkg::GLYPH_MED;
        else if (d10 < 160) shade = grc_pkg::GLYPH_LIGHT;
        else shade = grc_pkg::GLYPH_SPACE;
        for (int y = 0; y < 40; y++) begin
            rem = 40 - y;
            if (y <= ceil_r) g = grc_pkg::GLYPH_SPACE;
            else if (y <= floor_r) g = shade;
            else if (8 * rem < 40) g = grc_pkg::GLYPH_HASH;
            else if (4 * rem < 40) g = grc_pkg::GLYPH_X;
            else if (8 * rem < 120) g = grc_pkg::GLYPH_DOT;
            else if (20 * rem < 360) g = grc_pkg::GLYPH_DASH;
            else g = grc_pkg::GLYPH_SPACE;
            row_q.push_back(6'(y));
            glyph_q.push_back(g);
            last_q.push_back(y == 39);
        end
    endfunction

    function void check_glyph(logic [23:0] data, logic lst);
        logic [5:0] r;
        logic [15:0] g;
        logic l;
        if (row_q.size() == 0) begin
            $error("unexpected transfer: row %0d glyph %h", data[5:0], data[21:6]);
            errors++;
            return;
        end
        r = row_q.pop_front();
        g = glyph_q.pop_front();
        l = last_q.pop_front();
        if (data[5:0] !== r) begin
            $error("row: expected %0d actual %0d", r, data[5:0]); errors++;
        end
        if (data[21:6] !== g) begin
            $error("glyph: expected %h actual %h", g, data[21:6]); errors++;
        end
        if (lst !== l) begin
            $error("last: expected %0d actual %0d", l, lst); errors++;
        end
    endfunction
endclass

module grid_raycast_column_renderer_tb;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;  // pos_x_fix, pos_y_fix, heading, column, pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;       // row, glyph, pad
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    column_scoreboard board = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    longint cycle_count = 0;

    grid_raycast_column_renderer uut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Abort on a runaway run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Check output transfers and randomize receiver stalls.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_glyph(m_tdata, m_tlast);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hold tvalid across back-to-back columns; drop it only while idling.
    task automatic send_column(logic [15:0] px, logic [15:0] py, logic [15:0] hd,
                               logic [6:0] col);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {9'd0, col, hd, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_column(px, py, hd, col);
    endtask

    task automatic write_map(int idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= 3'(idx);
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.map_word[idx] = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait for every queued glyph, then let the back end settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.row_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic random_column();
        logic [15:0] px, py;
        if ($urandom_range(9) < 8) begin
            // Mostly poses inside the map interior.
            px = 16'($urandom_range(16'hEFFF, 16'h1000));
            py = 16'($urandom_range(16'hEFFF, 16'h1000));
        end else begin
            px = 16'($urandom);
            py = 16'($urandom);
        end
        send_column(px, py, 16'($urandom), 7'($urandom_range(127)));
    endtask

    initial begin
        logic [31:0] open_room [8];
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of pose, heading and column on the default room.
        send_column(16'h0000, 16'h0000, 16'h0000, 7'd0);
        send_column(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127);
        send_column(16'h8000, 16'h8000, 16'h0000, 7'd60);
        send_column(16'h8000, 16'h8000, 16'h4000, 7'd119);
        send_column(16'h8000, 16'h8000, 16'h8000, 7'd0);
        send_column(16'h8000, 16'h8000, 16'hC000, 7'd1);
        send_column(16'h1800, 16'h1800, 16'h2000, 7'd60);
        send_column(16'h0100, 16'h8000, 16'hC000, 7'd60);
        send_column(16'h8000, 16'h0100, 16'h8000, 7'd60);
        send_column(16'hAAAA, 16'h5555, 16'h5555, 7'd85);
        send_column(16'h5555, 16'hAAAA, 16'hAAAA, 7'd42);
        send_column(16'h2000, 16'h2000, 16'h2000, 7'd120);
        drain();

        // Empty map: every ray leaves the map; small negative points too.
        for (int k = 0; k < 8; k++) write_map(k, 32'h0);
        send_column(16'h0080, 16'h0080, 16'h8000, 7'd60);
        send_column(16'h0080, 16'h8000, 16'hC000, 7'd60);
        send_column(16'h8000, 16'h8000, 16'h1234, 7'd30);
        drain();

        // Full map: every ray ends on its first step, by a hit or by leaving the map.
        for (int k = 0; k < 8; k++) write_map(k, 32'hFFFFFFFF);
        send_column(16'h8000, 16'h8000, 16'h0000, 7'd0);
        send_column(16'h0000, 16'hFFFF, 16'hFFFF, 7'd119);
        drain();

        // Random phases over random maps and an open room, with idle and stall patterns.
        for (int ph = 0; ph < 5; ph++) begin
            for (int k = 0; k < 8; k++) begin
                if (ph == 4) open_room[k] = (k == 0) ? 32'h8001FFFF :
                                            (k == 7) ? 32'hFFFF8001 : 32'h80018001;
                else open_room[k] = $urandom & $urandom & $urandom;
                write_map(k, open_room[k]);
            end
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                3: begin send_idle_pct = 26; recv_stall_pct = 26; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < 56; i++) random_column();
            drain();
        end

        if (board.errors == 0 && board.row_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/grc_pkg.sv
rtl/core/grc_front.sv
rtl/core/grc_queue.sv
rtl/core/grc_back.sv
rtl/core/grid_raycast_column_renderer.sv
tb/sv/grid_raycast_column_renderer_tb.sv
